// File: sv/ihash_pkg.sv
// ----------------------------------------------------------------------------
// ihash_pkg
// Shared types and constants for the integer-key hash table.
// ----------------------------------------------------------------------------
package ihash_pkg;

  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int TOTAL_W    = 12;
  localparam int HASH_LO_W  = 16;
  localparam logic [HASH_LO_W-1:0] HASH_MUL = 16'd40503;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_SPARE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_ZERO_DATA = 2'd3
  } status_t;

  // outcome of one bucket row update
  typedef struct packed {
    logic             found;
    status_t          status;
    logic             wr;
    logic             inc;
    logic             dec;
    logic [VAL_W-1:0] value;
  } upd_res_t;

endpackage

// File: sv/int_key_hash_table.sv
// ----------------------------------------------------------------------------
// int_key_hash_table
// Hash table keyed by 32-bit integers with lookup, add and remove.
// ----------------------------------------------------------------------------
// Each bucket is one row of a single RAM holding all WAYS entries (key, data,
// valid, recency rank). An operation passes through three states: the first
// multiply of the hash as the word is taken, the bucket scaling and row read,
// then the compare of all ways and the row write-back, after which the result
// word is registered at the output; a stalled output holds the operation in
// its last state. One operation is in flight at a time; a new word is taken
// while the previous result waits at the output. After reset a clearing pass
// zeroes every row, during which no word is accepted.
module int_key_hash_table
  import ihash_pkg::*;
#(
  parameter int BUCKETS   = 256,
  parameter int WAYS      = 8,
  parameter int DATA_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // key[31:0], value_in[63:32]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // value_out[31:0], entry_total[43:32], zero
  output logic [2:0]  m_tuser    // found[0], status[2:1]
);

  localparam int AW      = $clog2(BUCKETS);
  localparam int BW      = $clog2(BUCKETS + 1);
  localparam int RANK_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ENTRY_W = KEY_W + DATA_BITS + 1 + RANK_W;
  localparam int ROW_W   = WAYS * ENTRY_W;
  localparam int CW      = $clog2(BUCKETS * WAYS + 1);
  localparam int SW      = HASH_LO_W + BW;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_HASH  = 4'b0100,
    S_MOD   = 4'b1000
  } state_t;

  state_t                  state, state_next;
  logic [AW-1:0]           clr_addr;
  kind_t                   kind;
  logic [KEY_W-1:0]        key;
  logic [VAL_W-1:0]        value_in;
  logic [HASH_LO_W-1:0]    hash_lo;
  logic [AW-1:0]           bkt;
  logic [CW-1:0]           cnt;
  logic [2*HASH_LO_W-1:0]  prod;
  logic [SW-1:0]           scaled;
  logic [AW-1:0]           bkt_calc;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [ROW_W-1:0]        ram_wdata;
  logic [AW-1:0]           ram_raddr;
  logic [ROW_W-1:0]        row_rd;
  logic [ROW_W-1:0]        row_wr;
  upd_res_t                res;
  logic                    s_acc;
  logic                    slot_free;
  logic                    commit;

  assign s_tready  = (state == S_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;
  assign commit    = (state == S_MOD) && slot_free;

  assign prod     = s_tdata[15:0] * HASH_MUL;
  assign scaled   = SW'(hash_lo) * SW'(BUCKETS);
  assign bkt_calc = scaled[HASH_LO_W +: AW];

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_addr == AW'(BUCKETS - 1)) state_next = S_IDLE;
      S_IDLE:  if (s_acc) state_next = S_HASH;
      S_HASH:  state_next = S_MOD;
      S_MOD:   if (slot_free) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (commit) begin
        if (res.inc) begin
          cnt <= cnt + CW'(1);
        end else if (res.dec) begin
          cnt <= cnt - CW'(1);
        end
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      kind     <= kind_t'(s_tuser);
      key      <= s_tdata[31:0];
      value_in <= s_tdata[63:32];
      hash_lo  <= prod[HASH_LO_W-1:0];
    end
    if (state == S_HASH) begin
      bkt <= bkt_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata[VAL_W-1:0]           <= res.value;
      m_tdata[VAL_W +: TOTAL_W]    <= res.inc ? TOTAL_W'(cnt + CW'(1)) :
                                      res.dec ? TOTAL_W'(cnt - CW'(1)) :
                                      TOTAL_W'(cnt);
      m_tdata[47:VAL_W+TOTAL_W]    <= '0;
      m_tuser[0]                   <= res.found;
      m_tuser[2:1]                 <= res.status;
    end
  end

  assign ram_raddr = (state == S_HASH) ? bkt_calc : bkt;
  assign ram_we    = (state == S_CLEAR) || (commit && res.wr);
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : bkt;
  assign ram_wdata = (state == S_CLEAR) ? '0 : row_wr;

  ihash_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (row_rd)
  );

  ihash_bucket_upd #(
    .WAYS      (WAYS),
    .DATA_BITS (DATA_BITS),
    .RANK_W    (RANK_W),
    .ENTRY_W   (ENTRY_W)
  ) u_upd (
    .kind     (kind),
    .key      (key),
    .value_in (value_in),
    .row_in   (row_rd),
    .row_out  (row_wr),
    .res      (res)
  );

  a_inc_dec_excl: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD) |-> !(res.inc && res.dec))
    else $error("add and remove at once");

  a_cnt_inc: assert property (@(posedge clk) disable iff (rst)
    (commit && res.inc) |=> (cnt == $past(cnt) + CW'(1)))
    else $error("entry count missed an add");

  a_cnt_dec: assert property (@(posedge clk) disable iff (rst)
    (commit && res.dec) |=> (cnt == $past(cnt) - CW'(1)))
    else $error("entry count missed a remove");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_MOD))
    else $error("result word without a row update");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tuser[2:1] == ST_OK))
    else $error("found with a failing status");

endmodule

// File: sv/ihash_ram.sv
// ----------------------------------------------------------------------------
// ihash_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ihash_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/ihash_bucket_upd.sv
// ----------------------------------------------------------------------------
// ihash_bucket_upd
// Compares all ways of one bucket row and builds the row to write back.
// ----------------------------------------------------------------------------
module ihash_bucket_upd
  import ihash_pkg::*;
#(
  parameter int WAYS      = 8,
  parameter int DATA_BITS = 32,
  parameter int RANK_W    = 3,
  parameter int ENTRY_W   = KEY_W + DATA_BITS + 1 + RANK_W
) (
  input  kind_t                     kind,
  input  logic [KEY_W-1:0]          key,
  input  logic [VAL_W-1:0]          value_in,
  input  logic [WAYS*ENTRY_W-1:0]   row_in,
  output logic [WAYS*ENTRY_W-1:0]   row_out,
  output upd_res_t                  res
);

  localparam int VAL_OFS  = KEY_W;
  localparam int VLD_OFS  = KEY_W + DATA_BITS;
  localparam int RANK_OFS = KEY_W + DATA_BITS + 1;

  logic [KEY_W-1:0]     k    [WAYS];
  logic [DATA_BITS-1:0] v    [WAYS];
  logic                 vld  [WAYS];
  logic [RANK_W-1:0]    rk   [WAYS];
  logic [WAYS-1:0]      match;
  logic [WAYS-1:0]      hit;
  logic [WAYS-1:0]      first_free;
  logic                 any_hit;
  logic                 any_free;
  logic                 seen_free;
  logic [DATA_BITS-1:0] vsel;
  logic [RANK_W-1:0]    rsel;
  logic [DATA_BITS-1:0] din;
  logic [63:0]          in64;
  logic [63:0]          out64;
  logic                 is_add;
  logic                 is_rem;
  logic                 do_add;
  logic                 do_rem;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      k[w]     = row_in[w*ENTRY_W +: KEY_W];
      v[w]     = row_in[w*ENTRY_W + VAL_OFS +: DATA_BITS];
      vld[w]   = row_in[w*ENTRY_W + VLD_OFS];
      rk[w]    = row_in[w*ENTRY_W + RANK_OFS +: RANK_W];
      match[w] = vld[w] && (k[w] == key);
    end
  end

  // newest match: no other match carries a lower rank
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hit[w] = match[w];
      for (int j = 0; j < WAYS; j++) begin
        if (j != w && match[j] && (rk[j] < rk[w])) begin
          hit[w] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    seen_free = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      first_free[w] = !vld[w] && !seen_free;
      seen_free     = seen_free || !vld[w];
    end
  end

  always_comb begin
    vsel = '0;
    rsel = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (hit[w]) begin
        vsel = vsel | v[w];
        rsel = rsel | rk[w];
      end
    end
  end

  assign any_hit  = |hit;
  assign any_free = |first_free;
  assign in64     = 64'(value_in);
  assign din      = in64[DATA_BITS-1:0];
  assign out64    = 64'(vsel);
  assign is_add   = (kind == KIND_ADD);
  assign is_rem   = (kind == KIND_REMOVE);
  assign do_add   = is_add && (din != '0) && any_free;
  assign do_rem   = is_rem && any_hit;

  always_comb begin
    row_out = row_in;
    for (int w = 0; w < WAYS; w++) begin
      if (do_add) begin
        if (first_free[w]) begin
          row_out[w*ENTRY_W +: KEY_W]                = key;
          row_out[w*ENTRY_W + VAL_OFS +: DATA_BITS]  = din;
          row_out[w*ENTRY_W + VLD_OFS]               = 1'b1;
          row_out[w*ENTRY_W + RANK_OFS +: RANK_W]    = '0;
        end else if (vld[w]) begin
          row_out[w*ENTRY_W + RANK_OFS +: RANK_W]    = rk[w] + RANK_W'(1);
        end
      end else if (do_rem) begin
        if (hit[w]) begin
          row_out[w*ENTRY_W + VLD_OFS]               = 1'b0;
          row_out[w*ENTRY_W + RANK_OFS +: RANK_W]    = '0;
        end else if (vld[w] && (rk[w] > rsel)) begin
          row_out[w*ENTRY_W + RANK_OFS +: RANK_W]    = rk[w] - RANK_W'(1);
        end
      end
    end
  end

  always_comb begin
    res.wr    = do_add || do_rem;
    res.inc   = do_add;
    res.dec   = do_rem;
    res.found = 1'b0;
    res.value = '0;
    if (is_add) begin
      if (din == '0) begin
        res.status = ST_ZERO_DATA;
      end else if (!any_free) begin
        res.status = ST_FULL;
      end else begin
        res.status = ST_OK;
      end
    end else if (any_hit) begin
      res.found  = 1'b1;
      res.value  = out64[VAL_W-1:0];
      res.status = ST_OK;
    end else begin
      res.status = ST_NOT_FOUND;
    end
  end

endmodule
